// ----- rtl/kdp_pkg.sv -----
// ----------------------------------------------------------------------------
// kdp_pkg
// Shared widths, phase and event codes, register indexes and reset values
// for the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdp_pkg;

   localparam int unsigned TICK_W    = 8;
   localparam int unsigned DEBOUNCE_W = 10;
   localparam int unsigned HOLD_W    = 16;
   localparam int unsigned ELAPSED_W = 11;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic [1:0] phase_type;
   typedef logic [1:0] event_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam phase_type PH_RELEASED   = 2'd0;
   localparam phase_type PH_PRESS_DB   = 2'd1;
   localparam phase_type PH_PRESSED    = 2'd2;
   localparam phase_type PH_RELEASE_DB = 2'd3;

   localparam event_type EV_NONE  = 2'd0;
   localparam event_type EV_SHORT = 2'd1;
   localparam event_type EV_LONG  = 2'd2;

   localparam csr_idx_type CSR_TICK_PERIOD = 2'd0;
   localparam csr_idx_type CSR_DEBOUNCE    = 2'd1;
   localparam csr_idx_type CSR_LONG_PRESS  = 2'd2;

   localparam logic [TICK_W-1:0]     TICK_PERIOD_RST = 8'd10;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST    = 10'd20;
   localparam logic [HOLD_W-1:0]     LONG_PRESS_RST  = 16'd100;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [HOLD_W-1:0]    HOLD_MAX    = '1;

endpackage

// ----- rtl/key_debounce_press_classifier.sv -----
// ----------------------------------------------------------------------------
// key_debounce_press_classifier
// Debounces an active-low key pin sampled once per scan tick and classifies
// each press as short or long.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the req_ channel is one scan tick carrying the raw pin level
//   (0 means the key is down). For every item exactly one result leaves on
//   the rsp_ channel: the press event register and the debounce phase, both
//   as they stand after that tick.
//   The result is registered: an item accepted in one cycle shows its result
//   in the next. One item is taken per clock cycle while req_stall is low;
//   the state registers and the result register are updated by the same
//   edge, so throughput is limited only by the receiver.
//   While the receiver stalls, the result holds and req_stall is raised only
//   when the result register is full and stalled, so a new item is taken in
//   the same cycle the waiting result leaves.
//   Synchronous reset returns the machine to the released phase with no
//   event, clears the counters and loads the register defaults (tick period
//   10 ms, debounce 20 ms, long press 100 ticks). Registers are written
//   through the csr_ port, by the user only while the block is idle (not
//   enforced by the block); an index beyond the register list is ignored.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier
   import kdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_pin_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_key_event,
   output logic [1:0]            rsp_key_phase,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TICK_W-1:0]     tick_period_ff;
   logic [DEBOUNCE_W-1:0] debounce_ff;
   logic [HOLD_W-1:0]     long_press_ff;

   phase_type             phase_ff, phase_in;
   event_type             event_ff, event_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  down;
   logic [ELAPSED_W:0]    elapsed_sum;
   logic [ELAPSED_W-1:0]  elapsed_sat;
   logic                  db_done;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign down      = !req_pin_level;

   // Debounce timer: saturating add, then compare against the debounce time.
   assign elapsed_sum = {1'b0, elapsed_ff} + {{(ELAPSED_W + 1 - TICK_W){1'b0}}, tick_period_ff};
   assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
   assign db_done     = elapsed_sat >= {{(ELAPSED_W - DEBOUNCE_W){1'b0}}, debounce_ff};

   always_comb begin
      phase_in   = phase_ff;
      event_in   = event_ff;
      elapsed_in = elapsed_ff;
      hold_in    = hold_ff;
      unique case (phase_ff)
         PH_RELEASED: begin
            phase_in   = down ? PH_PRESS_DB : PH_RELEASED;
            elapsed_in = '0;
            event_in   = EV_NONE;
         end
         PH_PRESS_DB: begin
            elapsed_in = elapsed_sat;
            if (db_done) begin
               phase_in   = down ? PH_PRESSED : PH_RELEASED;
               hold_in    = '0;
               elapsed_in = '0;
            end
         end
         PH_PRESSED: begin
            if (down) begin
               event_in = (hold_ff == long_press_ff) ? EV_LONG : EV_NONE;
               // The count stops one above the limit, or at full scale.
               if (hold_ff <= long_press_ff && hold_ff != HOLD_MAX) begin
                  hold_in = hold_ff + HOLD_W'(1);
               end
            end else begin
               phase_in = PH_RELEASE_DB;
            end
         end
         PH_RELEASE_DB: begin
            elapsed_in = elapsed_sat;
            if (db_done) begin
               elapsed_in = '0;
               if (down) begin
                  phase_in = PH_PRESSED;
               end else begin
                  phase_in = PH_RELEASED;
                  if (hold_ff < long_press_ff) begin
                     event_in = EV_SHORT;
                  end
                  hold_in = '0;
               end
            end
         end
         default: begin
            phase_in = PH_RELEASED;
         end
      endcase
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_PERIOD_RST;
         debounce_ff    <= DEBOUNCE_RST;
         long_press_ff  <= LONG_PRESS_RST;
         phase_ff       <= PH_RELEASED;
         event_ff       <= EV_NONE;
         elapsed_ff     <= '0;
         hold_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TICK_PERIOD: tick_period_ff <= csr_wdata[TICK_W-1:0];
               CSR_DEBOUNCE:    debounce_ff    <= csr_wdata[DEBOUNCE_W-1:0];
               CSR_LONG_PRESS:  long_press_ff  <= csr_wdata[HOLD_W-1:0];
               default: begin
               end
            endcase
         end
         // The state after the update is also the result, so the state
         // registers double as the result register.
         if (accept) begin
            phase_ff   <= phase_in;
            event_ff   <= event_in;
            elapsed_ff <= elapsed_in;
            hold_ff    <= hold_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = event_ff;
   assign rsp_key_phase = phase_ff;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result");

   a_short_only_released: assert property (@(posedge clock) disable iff (reset)
      (event_ff == EV_SHORT) |-> (phase_ff == PH_RELEASED))
      else $error("short press reported outside the released phase");

   a_no_direct_release: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PRESSED) |=> (phase_ff != PH_RELEASED))
      else $error("pressed phase left without release debounce");

   a_hold_bounded: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_PRESSED && hold_ff > long_press_ff) |=>
         $stable(hold_ff))
      else $error("hold count grew past its saturation point");
`endif

endmodule
